[rtl/core/cwd_pkg.sv]
// Package for the chemosensor window difference block: history sizing, field widths,
// register map and saturation limit.
// No dependencies.
`timescale 1ns / 1ps

package cwd_pkg;

	// History ring. The depth must be a power of two, so that the ring index wraps by truncation.
	localparam int unsigned HIST_DEPTH  = 512;
	localparam int unsigned HIST_AW     = $clog2(HIST_DEPTH);
	localparam int unsigned SAMPLE_BITS = 24;

	// Field and register widths.
	localparam int unsigned WIN_BITS   = 8;
	localparam int unsigned AGE_BITS   = WIN_BITS + 1;
	localparam int unsigned CMP_BITS   = (HIST_AW > AGE_BITS) ? HIST_AW : AGE_BITS;
	localparam int unsigned RECIP_BITS = 17;
	localparam int unsigned LEVEL_BITS = 24;
	localparam int unsigned SUM_BITS   = 32;
	localparam int unsigned PROD_BITS  = SUM_BITS + RECIP_BITS + 1;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned MEAN_BITS  = PROD_BITS - FRAC_BITS;
	localparam int unsigned DIFF_BITS  = MEAN_BITS + 1;
	localparam int unsigned RESP_BITS  = 23;

	// Bus widths.
	localparam int unsigned ADDR_BITS = 5;
	localparam int unsigned DATA_BITS = 32;

	localparam logic [DIFF_BITS-1:0] RESP_MAX = DIFF_BITS'((64'd1 << RESP_BITS) - 64'd1);

	// Register indices (byte address divided by four).
	typedef enum logic [2:0] {
		REG_PRESENT_WINDOW = 3'd0,
		REG_PAST_WINDOW    = 3'd1,
		REG_PRESENT_RECIP  = 3'd2,
		REG_PAST_RECIP     = 3'd3,
		REG_START_LEVEL    = 3'd4
	} reg_idx_t;

endpackage

[rtl/core/chemosensor_window_difference.sv]
// Top level of the chemosensor window difference block: sample ring, running sums,
// reciprocal scaling and rectified ON/OFF outputs. Depends on cwd_pkg.
// Path of a word: stage 1 registers, running sums, product registers, output register.
// Throughput: one word per cycle when not stalled; the ring has one write and two read ports.
// Reset clears the pointers, fill count, pipeline valids and registers to their reset values;
// the history memory is not cleared, as the fill count masks every entry not yet written.
`timescale 1ns / 1ps

module chemosensor_window_difference
	import cwd_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	// APB-style configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_BITS-1:0]          paddr,
	input  logic [DATA_BITS-1:0]          pwdata,
	output logic [DATA_BITS-1:0]          prdata,
	output logic                          pready,
	// Sample channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] concentration,
	// Response channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [RESP_BITS-1:0]          on_response,
	output logic [RESP_BITS-1:0]          off_response
);

	// ------------------------------------------------------------------
	// Configuration registers. They are to be written only while the block is
	// idle, which the block itself does not enforce, so the pipeline reads them directly.
	// ------------------------------------------------------------------
	logic [WIN_BITS-1:0]          present_window_q;
	logic [WIN_BITS-1:0]          past_window_q;
	logic [RECIP_BITS-1:0]        present_recip_q;
	logic [RECIP_BITS-1:0]        past_recip_q;
	logic signed [LEVEL_BITS-1:0] start_level_q;

	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_window_q <= WIN_BITS'(1);
			past_window_q    <= WIN_BITS'(1);
			present_recip_q  <= RECIP_BITS'(65536);
			past_recip_q     <= RECIP_BITS'(65536);
			start_level_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PRESENT_WINDOW: present_window_q <= pwdata[WIN_BITS-1:0];
				REG_PAST_WINDOW:    past_window_q    <= pwdata[WIN_BITS-1:0];
				REG_PRESENT_RECIP:  present_recip_q  <= pwdata[RECIP_BITS-1:0];
				REG_PAST_RECIP:     past_recip_q     <= pwdata[RECIP_BITS-1:0];
				REG_START_LEVEL:    start_level_q    <= pwdata[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_PRESENT_WINDOW: prdata = DATA_BITS'(present_window_q);
			REG_PAST_WINDOW:    prdata = DATA_BITS'(past_window_q);
			REG_PRESENT_RECIP:  prdata = DATA_BITS'(present_recip_q);
			REG_PAST_RECIP:     prdata = DATA_BITS'(past_recip_q);
			REG_START_LEVEL:    prdata = DATA_BITS'($unsigned(start_level_q));
			default:            prdata = '0;
		endcase
	end

	// The priming values for the first word. They follow the configuration
	// every cycle, so they are settled before any word can reach them.
	logic [SUM_BITS-1:0] prime_recent_q;
	logic [SUM_BITS-1:0] prime_older_q;

	always_ff @(posedge clk) begin
		prime_recent_q <= SUM_BITS'(start_level_q * $signed({1'b0, present_window_q}));
		prime_older_q  <= SUM_BITS'(start_level_q * $signed({1'b0, past_window_q}));
	end

	// ------------------------------------------------------------------
	// Flow control. Each stage moves on when it is empty or when the stage
	// after it moves, so bubbles close up and the input is still taken
	// while a finished result waits at the output, until the stages fill.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic out_en, s3_en, s2_en, s1_en;
	logic accept;

	assign out_en   = !out_valid || !out_stall;
	assign s3_en    = !v_s3 || out_en;
	assign s2_en    = !v_s2 || s3_en;
	assign s1_en    = !v_s1 || s2_en;
	assign in_stall = !s1_en;
	assign accept   = in_valid && s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= in_valid;
			end
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (s3_en) begin
				v_s3 <= v_s2;
			end
			if (out_en) begin
				out_valid <= v_s3;
			end
		end
	end

	// ------------------------------------------------------------------
	// Accept stage: ring pointer, fill count and read addresses. The new
	// sample goes in at the write pointer; an age a lies at pointer minus a.
	// The fill count saturates one below the depth, so any age that the
	// ring cannot hold also reads as the start level.
	// ------------------------------------------------------------------
	logic [HIST_AW-1:0]  wr_ptr_q;
	logic [HIST_AW-1:0]  fill_q;
	logic [HIST_AW-1:0]  fill_next;
	logic [AGE_BITS-1:0] mid_age;
	logic [AGE_BITS-1:0] far_age;
	logic [HIST_AW-1:0]  mid_addr;
	logic [HIST_AW-1:0]  far_addr;
	logic                mid_ok;
	logic                far_ok;

	assign fill_next = (fill_q != HIST_AW'(HIST_DEPTH - 1)) ? fill_q + 1'b1 : fill_q;
	assign mid_age   = AGE_BITS'(present_window_q);
	assign far_age   = AGE_BITS'(present_window_q) + AGE_BITS'(past_window_q);
	assign mid_addr  = wr_ptr_q - HIST_AW'(mid_age);
	assign far_addr  = wr_ptr_q - HIST_AW'(far_age);
	assign mid_ok    = CMP_BITS'(mid_age) < CMP_BITS'(fill_next);
	assign far_ok    = CMP_BITS'(far_age) < CMP_BITS'(fill_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			wr_ptr_q <= wr_ptr_q + 1'b1;
			fill_q   <= fill_next;
		end
	end

	// History memory: one write and two registered reads per cycle. A read
	// at the entry written in the same cycle sees old data; that case is an
	// age of zero and is forwarded from the incoming sample below.
	logic [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
	logic [SAMPLE_BITS-1:0] mid_rd_s1;
	logic [SAMPLE_BITS-1:0] far_rd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[wr_ptr_q] <= concentration;
			mid_rd_s1          <= hist_mem[mid_addr];
			far_rd_s1          <= hist_mem[far_addr];
		end
	end

	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          first_s1;
	logic                          mid_ok_s1, far_ok_s1;
	logic                          mid_fwd_s1, far_fwd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1       <= concentration;
			first_s1   <= (fill_q == '0);
			mid_ok_s1  <= mid_ok;
			far_ok_s1  <= far_ok;
			mid_fwd_s1 <= (mid_age == '0);
			far_fwd_s1 <= (far_age == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: pick the samples that leave each window and update the
	// running sums. The sums move when the word moves on to stage 2, so the
	// next word in stage 1 always sees the updated values.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_BITS-1:0] mid_s1;
	logic signed [SAMPLE_BITS-1:0] far_s1;
	logic [SUM_BITS-1:0]           recent_sum_q;
	logic [SUM_BITS-1:0]           older_sum_q;
	logic [SUM_BITS-1:0]           recent_base;
	logic [SUM_BITS-1:0]           older_base;
	logic [SUM_BITS-1:0]           recent_delta;
	logic [SUM_BITS-1:0]           older_delta;

	always_comb begin
		if (mid_fwd_s1) begin
			mid_s1 = x_s1;
		end else if (mid_ok_s1) begin
			mid_s1 = mid_rd_s1;
		end else begin
			mid_s1 = SAMPLE_BITS'(start_level_q);
		end
		if (far_fwd_s1) begin
			far_s1 = x_s1;
		end else if (far_ok_s1) begin
			far_s1 = far_rd_s1;
		end else begin
			far_s1 = SAMPLE_BITS'(start_level_q);
		end
	end

	assign recent_base  = first_s1 ? prime_recent_q : recent_sum_q;
	assign older_base   = first_s1 ? prime_older_q : older_sum_q;
	assign recent_delta = SUM_BITS'(x_s1 - mid_s1);
	assign older_delta  = SUM_BITS'(mid_s1 - far_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_sum_q <= '0;
			older_sum_q  <= '0;
		end else if (v_s1 && s2_en) begin
			recent_sum_q <= recent_base + recent_delta;
			older_sum_q  <= older_base + older_delta;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: scale each sum by its Q1.16 reciprocal (32 x 18 signed).
	// ------------------------------------------------------------------
	logic signed [PROD_BITS-1:0] recent_prod;
	logic signed [PROD_BITS-1:0] older_prod;
	logic signed [PROD_BITS-1:0] recent_prod_s3;
	logic signed [PROD_BITS-1:0] older_prod_s3;

	assign recent_prod = $signed(recent_sum_q) * $signed({1'b0, present_recip_q});
	assign older_prod  = $signed(older_sum_q) * $signed({1'b0, past_recip_q});

	always_ff @(posedge clk) begin
		if (s3_en) begin
			recent_prod_s3 <= recent_prod;
			older_prod_s3  <= older_prod;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: drop the fraction (an arithmetic shift floors), take the
	// difference of the means and split it into saturated ON and OFF parts.
	// ------------------------------------------------------------------
	logic signed [MEAN_BITS-1:0] recent_mean;
	logic signed [MEAN_BITS-1:0] older_mean;
	logic signed [DIFF_BITS-1:0] diff;
	logic signed [DIFF_BITS-1:0] neg_diff;
	logic [RESP_BITS-1:0]        on_next;
	logic [RESP_BITS-1:0]        off_next;

	assign recent_mean = recent_prod_s3[PROD_BITS-1:FRAC_BITS];
	assign older_mean  = older_prod_s3[PROD_BITS-1:FRAC_BITS];
	assign diff        = DIFF_BITS'(recent_mean) - DIFF_BITS'(older_mean);
	assign neg_diff    = -diff;

	always_comb begin
		on_next  = '0;
		off_next = '0;
		if (diff > 0) begin
			if (diff > $signed(RESP_MAX)) begin
				on_next = RESP_MAX[RESP_BITS-1:0];
			end else begin
				on_next = diff[RESP_BITS-1:0];
			end
		end else if (diff < 0) begin
			if (neg_diff > $signed(RESP_MAX)) begin
				off_next = RESP_MAX[RESP_BITS-1:0];
			end else begin
				off_next = neg_diff[RESP_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			on_response  <= on_next;
			off_response <= off_next;
		end
	end

endmodule

[verif/cwd_response_checker.sv]
// Response checker for the chemosensor window difference block: watches the configuration
// port and both word channels, predicts each ON/OFF response and compares it on arrival.
// Depends on cwd_pkg.
`timescale 1ns / 1ps

module cwd_response_checker
	import cwd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_BITS-1:0]   paddr,
	input  logic [DATA_BITS-1:0]   pwdata,
	input  logic                   pready,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] concentration,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [RESP_BITS-1:0]   on_response,
	input  logic [RESP_BITS-1:0]   off_response,
	output int                     failures,
	output int                     waiting,
	output int                     responses_checked
);

	typedef struct packed {
		logic [RESP_BITS-1:0] on_part;
		logic [RESP_BITS-1:0] off_part;
	} response_t;

	localparam longint RESP_LIMIT = (64'sd1 <<< RESP_BITS) - 1;

	response_t due_responses[$];

	logic [SAMPLE_BITS-1:0] sample_ring [HIST_DEPTH];
	logic [HIST_AW-1:0]     ring_ptr;
	int unsigned            ring_fill;
	logic [SUM_BITS-1:0]    recent_total;
	logic [SUM_BITS-1:0]    older_total;

	logic [WIN_BITS-1:0]    cur_present_window;
	logic [WIN_BITS-1:0]    cur_past_window;
	logic [RECIP_BITS-1:0]  cur_present_recip;
	logic [RECIP_BITS-1:0]  cur_past_recip;
	logic [LEVEL_BITS-1:0]  cur_start_level;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		failures++;
	endtask

	// Sample of the given age, with anything older than the written history read as the
	// start level.
	function automatic longint level_at(input int unsigned age);
		logic [HIST_AW-1:0] idx;
		if (age >= ring_fill)
			return longint'(signed'(cur_start_level));
		idx = ring_ptr - HIST_AW'(1) - HIST_AW'(age);
		return longint'(signed'(sample_ring[idx]));
	endfunction

	// Sum times a Q1.16 reciprocal, floored by the arithmetic shift.
	function automatic longint floored_mean(input logic [SUM_BITS-1:0] sum,
			input logic [RECIP_BITS-1:0] recip);
		longint product;
		product = longint'(signed'(sum)) * longint'(recip);
		return product >>> FRAC_BITS;
	endfunction

	task automatic predict_response(input logic [SAMPLE_BITS-1:0] sample);
		longint    level;
		longint    newest;
		longint    middle;
		longint    oldest;
		longint    diff;
		response_t resp;
		if (ring_fill == 0) begin
			level        = longint'(signed'(cur_start_level));
			recent_total = SUM_BITS'(level * longint'(cur_present_window));
			older_total  = SUM_BITS'(level * longint'(cur_past_window));
		end
		sample_ring[ring_ptr] = sample;
		ring_ptr = ring_ptr + HIST_AW'(1);
		if (ring_fill < HIST_DEPTH - 1)
			ring_fill++;
		newest = level_at(0);
		middle = level_at(int'(cur_present_window));
		oldest = level_at(int'(cur_present_window) + int'(cur_past_window));
		recent_total = recent_total + SUM_BITS'(newest - middle);
		older_total  = older_total + SUM_BITS'(middle - oldest);
		diff = floored_mean(recent_total, cur_present_recip)
			- floored_mean(older_total, cur_past_recip);
		resp.on_part  = RESP_BITS'((diff > 0) ? ((diff > RESP_LIMIT) ? RESP_LIMIT : diff) : 0);
		resp.off_part = RESP_BITS'((diff < 0) ? ((-diff > RESP_LIMIT) ? RESP_LIMIT : -diff) : 0);
		due_responses = {due_responses, resp};
	endtask

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			due_responses.delete();
			ring_ptr           = '0;
			ring_fill          = 0;
			recent_total       = '0;
			older_total        = '0;
			cur_present_window = WIN_BITS'(1);
			cur_past_window    = WIN_BITS'(1);
			cur_present_recip  = RECIP_BITS'(65536);
			cur_past_recip     = RECIP_BITS'(65536);
			cur_start_level    = '0;
			failures           = 0;
			waiting            = 0;
			responses_checked  = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_BITS-1:2])
					REG_PRESENT_WINDOW: cur_present_window = pwdata[WIN_BITS-1:0];
					REG_PAST_WINDOW:    cur_past_window    = pwdata[WIN_BITS-1:0];
					REG_PRESENT_RECIP:  cur_present_recip  = pwdata[RECIP_BITS-1:0];
					REG_PAST_RECIP:     cur_past_recip     = pwdata[RECIP_BITS-1:0];
					REG_START_LEVEL:    cur_start_level    = pwdata[LEVEL_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_response(concentration);
			if (out_valid && !out_stall) begin
				if (due_responses.size() == 0) begin
					report_mismatch("response with nothing outstanding",
						longint'(on_response), 0);
				end else begin
					want = due_responses.pop_front();
					if (on_response !== want.on_part)
						report_mismatch("on_response", longint'(on_response),
							longint'(want.on_part));
					if (off_response !== want.off_part)
						report_mismatch("off_response", longint'(off_response),
							longint'(want.off_part));
				end
				responses_checked++;
			end
			waiting = due_responses.size();
		end
	end

endmodule

[verif/chemosensor_window_difference_tb.sv]
// Testbench top for the chemosensor window difference block: clock, reset, register
// programming, sample stimulus and output stalls. Depends on cwd_pkg and cwd_response_checker.
`timescale 1ns / 1ps

module chemosensor_window_difference_tb;
	import cwd_pkg::*;

	// Idle cycles run after the last response is taken, before the test ends.
	localparam int DRAIN_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 110;
	localparam int HOLD_CYCLES   = 48;
	localparam int SQUEEZE_PHASE = 3;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_BITS-1:0] concentration = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [RESP_BITS-1:0] on_response;
	logic [RESP_BITS-1:0] off_response;

	int failures;
	int waiting;
	int responses_checked;

	// Stimulus control and counters; calm and hold_off_req are shared with the receiver.
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;
	int words_sent = 0;
	int settings_used = 0;
	int cycles = 0;
	logic signed [SAMPLE_BITS-1:0] trend = '0;

	chemosensor_window_difference uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.concentration(concentration),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.on_response  (on_response),
		.off_response (off_response)
	);

	cwd_response_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.concentration    (concentration),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.on_response      (on_response),
		.off_response     (off_response),
		.failures         (failures),
		.waiting          (waiting),
		.responses_checked(responses_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d responses outstanding.", cycles, waiting);
			$display("chemosensor_window_difference test failed");
			$finish;
		end
	end

	// Receiver. It stalls in short random bursts, except in the last phase, and once holds
	// off for a long stretch so that the pipeline fills and pushes back on the sender.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && arst_n && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// One register write: a setup phase, then the access phase held until pready.
	task automatic reg_write(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Waits until every response predicted so far has been taken. The first edge makes sure
	// the checker has seen the last accepted word before its count is read.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
	endtask

	task automatic program_setting(input int present_w, input int past_w, input int present_r,
			input int past_r, input logic [LEVEL_BITS-1:0] level);
		settle();
		reg_write(REG_PRESENT_WINDOW, DATA_BITS'(present_w));
		reg_write(REG_PAST_WINDOW, DATA_BITS'(past_w));
		reg_write(REG_PRESENT_RECIP, DATA_BITS'(present_r));
		reg_write(REG_PAST_RECIP, DATA_BITS'(past_r));
		reg_write(REG_START_LEVEL, DATA_BITS'(level));
		settings_used++;
	endtask

	// Offers one word, sometimes after a short idle burst, and returns at the edge where it
	// is accepted. Valid stays high between back-to-back words.
	task automatic offer_word(input logic signed [SAMPLE_BITS-1:0] value);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid      <= 1'b0;
			concentration <= SAMPLE_BITS'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		concentration <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// Mostly a slowly drifting level, as a sensor would see, with full-range noise and
	// extreme values mixed in.
	function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
		case ($urandom_range(0, 7))
			0, 1: return SAMPLE_BITS'($urandom);
			2: begin
				case ($urandom_range(0, 4))
					0: return SAMPLE_MAX;
					1: return SAMPLE_MIN;
					2: return 24'sd0;
					3: return -24'sd1;
					default: return 24'sd1;
				endcase
			end
			default: begin
				trend = trend + SAMPLE_BITS'($urandom_range(0, 1023)) - 24'sd512;
				return trend;
			end
		endcase
	endfunction

	function automatic int pick_recip(input int window);
		if (window == 0 || $urandom_range(0, 3) == 0)
			return $urandom_range(0, 131071);
		return (65536 + window / 2) / window;
	endfunction

	initial begin
		int present_w;
		int past_w;
		logic signed [SAMPLE_BITS-1:0] directed [$];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first word primes both sums from the start level, so a negative level and
		// unequal windows are set before it; young history also reads as that level.
		program_setting(3, 5, 21845, 13107, 24'hFFF600);
		directed = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
			24'sd0, -24'sd1, 24'sd1, 24'sh555555, 24'shAAAAAA, 24'sd256};
		foreach (directed[i])
			offer_word(directed[i]);

		// Single-sample windows at unit scale: full-scale swings saturate both outputs.
		program_setting(1, 1, 65536, 65536, 24'h7FFFFF);
		directed = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 24'sd0, SAMPLE_MIN};
		foreach (directed[i])
			offer_word(directed[i]);

		// Zero windows hold both sums, with the reciprocals at their two extremes.
		program_setting(0, 0, 131071, 0, 24'h800000);
		directed = '{24'sd100, -24'sd100, 24'sd5, SAMPLE_MAX};
		foreach (directed[i])
			offer_word(directed[i]);

		// Random phases, each under its own setting. The first uses the widest windows with
		// the lowest start level, so the young history reaches far back; the last has no
		// idling on either side.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				program_setting(255, 255, 257, 257, 24'h800000);
			end else begin
				present_w = $urandom_range(0, 255);
				past_w    = $urandom_range(0, 255);
				program_setting(present_w, past_w, pick_recip(present_w), pick_recip(past_w),
					LEVEL_BITS'($urandom));
			end
			if (phase == RANDOM_PHASES - 1)
				calm = 1'b1;
			if (phase == SQUEEZE_PHASE)
				hold_off_req = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++)
				offer_word(next_sample());
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d sample words under %0d register settings; %0d responses checked.",
			words_sent, settings_used, responses_checked);
		$display("Covered full-scale saturation, zero and 255-sample windows, reciprocal extremes and a long output hold-off.");
		if (failures == 0 && waiting == 0) begin
			$display("chemosensor_window_difference test passed");
		end else begin
			$display("%0d mismatches, %0d responses never arrived.", failures, waiting);
			$display("chemosensor_window_difference test failed");
		end
		$finish;
	end

endmodule
